@@ design/assert_macros.svh @@
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge, masked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tracker assertion failed");
// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tracker invariant failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ design/cyct_pkg.sv @@
// Types and constants of the collection cycle report tracker.
package cyct_pkg;

  localparam int FUNC_W   = 2;
  localparam int NOW_W    = 32;
  localparam int MAC_W    = 48;
  localparam int IV_W     = 17;
  localparam int EXP_W    = 5;
  localparam int WAKE_W   = 33;
  localparam int STATUS_W = 3;
  localparam int RCNT_W   = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START  = 2'd0,
    FUNC_REPORT = 2'd1,
    FUNC_BCAST  = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OUTSIDE   = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_ACCEPTED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_CYCLE     = 3'd4,
    ST_BCAST     = 3'd5,
    ST_REFUSED   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    REG_INTERVAL = 2'd0,
    REG_WINDOW   = 2'd1,
    REG_EXPECTED = 2'd2,
    REG_BCAST_IV = 2'd3
  } reg_e;

  localparam logic [IV_W-1:0]  INTERVAL_RST = 17'd300;
  localparam logic [IV_W-1:0]  WINDOW_RST   = 17'd60;
  localparam logic [EXP_W-1:0] EXPECTED_RST = 5'd2;
  localparam logic [IV_W-1:0]  BCAST_IV_RST = 17'd300;

  typedef struct packed {
    logic [IV_W-1:0]  interval;
    logic [IV_W-1:0]  window;
    logic [EXP_W-1:0] expected;
    logic [IV_W-1:0]  bcast_iv;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic scan_en;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic out_blocked;
  } sts_t;

endpackage

@@ design/cyct_intf.sv @@
// Request and response channel interfaces of the tracker.
interface cyct_req_if;
  logic                         valid;
  logic                         ready;
  logic [cyct_pkg::FUNC_W-1:0]  func;
  logic [cyct_pkg::NOW_W-1:0]   now_sec;
  logic [cyct_pkg::MAC_W-1:0]   node_mac;

  modport source (output valid, func, now_sec, node_mac, input ready);
  modport sink   (input valid, func, now_sec, node_mac, output ready);
endinterface

interface cyct_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cyct_pkg::STATUS_W-1:0] status;
  logic [cyct_pkg::RCNT_W-1:0]   reported_count;
  logic                          cycle_complete;
  logic                          window_active;
  logic                          broadcast_sent;
  logic [cyct_pkg::WAKE_W-1:0]   next_wake;
  logic [cyct_pkg::IV_W-1:0]     sleep_duration;
  logic                          broadcast_due;

  modport source (output valid, status, reported_count, cycle_complete, window_active,
                  broadcast_sent, next_wake, sleep_duration, broadcast_due,
                  input ready);
  modport sink   (input valid, status, reported_count, cycle_complete, window_active,
                  broadcast_sent, next_wake, sleep_duration, broadcast_due,
                  output ready);
endinterface

@@ design/cyct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cyct_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/cyct_div.sv @@
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module cyct_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cyct_pkg::NOW_W-1:0] dividend_i,
  input  logic [cyct_pkg::IV_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [cyct_pkg::IV_W-1:0]  rem_o
);

  localparam int NW    = cyct_pkg::NOW_W;
  localparam int DW    = cyct_pkg::IV_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NW-1:0]    dvd_q;
  logic [DW-1:0]    rem_q;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;

  assign trial = {rem_q, dvd_q[NW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NW-2:0], 1'b0};
      rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

@@ design/cyct_ctrl.sv @@
// Sequencer of the tracker: accept, scan and divide, commit.
`include "assert_macros.svh"

module cyct_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cyct_pkg::sts_t sts_i,
  output cyct_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load      = 1'b1;
          cmd_o.div_start = 1'b1;
          state_d         = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done && sts_i.div_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // hold until the output register has room
        if (!sts_i.out_blocked) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_CLK(a_commit_after_work, clk_i, rst_ni, cmd_o.commit |-> sts_i.scan_done && sts_i.div_done)
  `ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, accept |=> !in_ready_o)

endmodule

@@ design/cyct_dp.sv @@
// Datapath of the tracker: cycle state, table scan, scheduling, result register.
`include "assert_macros.svh"

module cyct_dp #(
  parameter int MAX_SENSORS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cyct_pkg::cfg_t              cfg_i,
  input  logic [cyct_pkg::FUNC_W-1:0] func_i,
  input  logic [cyct_pkg::NOW_W-1:0]  now_sec_i,
  input  logic [cyct_pkg::MAC_W-1:0]  node_mac_i,
  input  cyct_pkg::cmd_t              cmd_i,
  output cyct_pkg::sts_t              sts_o,
  cyct_rsp_if.source                  rsp_o
);

  localparam int CNT_W = $clog2(MAX_SENSORS + 1);
  localparam int AW    = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CMP_W = (CNT_W > cyct_pkg::EXP_W) ? CNT_W : cyct_pkg::EXP_W;
  localparam int NW    = cyct_pkg::NOW_W;
  localparam int WW    = cyct_pkg::WAKE_W;
  localparam int IW    = cyct_pkg::IV_W;

  // captured request
  cyct_pkg::func_e     func_q;
  logic [NW-1:0]       now_q;
  logic [cyct_pkg::MAC_W-1:0] mac_q;

  // cycle state
  logic [CNT_W-1:0]    count_q, count_d;
  logic [NW-1:0]       cs_q, cs_d;
  logic [WW-1:0]       dl_q, dl_d;
  logic [WW-1:0]       wake_q, wake_d;
  logic [NW-1:0]       last_q, last_d;
  logic                synced_q, synced_d;

  // table scan
  logic [CNT_W-1:0]    idx_q;
  logic                rd_pend_q;
  logic                dup_q;
  logic                rd_en;
  logic [cyct_pkg::MAC_W-1:0] rd_data;
  logic                tbl_wr;

  // divider
  logic                div_busy;
  logic [IW-1:0]       rem;
  logic [IW-1:0]       iv_eff;

  // commit logic
  logic [WW-1:0]       now_ext;
  logic [WW-1:0]       wake_sched;
  logic [WW-1:0]       dl_sched;
  logic [CNT_W-1:0]    cnt_inc;
  logic                in_win_pre;
  logic                full;
  logic                reach;
  logic                sched;
  cyct_pkg::status_e   status_n;
  logic                complete_n;
  logic                sent_n;
  logic                win_n;
  logic                due_n;

  // result register
  logic                out_valid_q;
  logic [cyct_pkg::STATUS_W-1:0] status_q;
  logic [cyct_pkg::RCNT_W-1:0]   rcount_q;
  logic                complete_q;
  logic                win_q;
  logic                sent_q;
  logic [WW-1:0]       next_wake_q;
  logic [IW-1:0]       sleep_q;
  logic                due_q;

  assign iv_eff = (cfg_i.interval == '0) ? IW'(1) : cfg_i.interval;

  cyct_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (now_sec_i),
    .divisor_i  (iv_eff),
    .busy_o     (div_busy),
    .rem_o      (rem)
  );

  cyct_ram #(
    .WIDTH (cyct_pkg::MAC_W),
    .DEPTH (MAX_SENSORS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_wr),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (mac_q),
    .re_i    (rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= cyct_pkg::func_e'(func_i);
      now_q  <= now_sec_i;
      mac_q  <= node_mac_i;
    end
  end

  // one table read per cycle over the entries recorded so far
  assign rd_en = cmd_i.scan_en && (func_q == cyct_pkg::FUNC_REPORT) && (idx_q < count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      dup_q     <= 1'b0;
    end else begin
      rd_pend_q <= rd_en;
      if (cmd_i.load) begin
        idx_q <= '0;
        dup_q <= 1'b0;
      end else begin
        if (rd_en) begin
          idx_q <= idx_q + CNT_W'(1);
        end
        if (rd_pend_q && (rd_data == mac_q)) begin
          dup_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.scan_done   = !((func_q == cyct_pkg::FUNC_REPORT) && (idx_q < count_q))
                             && !rd_pend_q;
  assign sts_o.div_done    = !div_busy;
  assign sts_o.out_blocked = out_valid_q && !rsp_o.ready;

  // next wake = now rounded up past the next interval multiple
  assign now_ext    = {1'b0, now_q};
  assign wake_sched = now_ext - WW'(rem) + WW'(iv_eff);
  assign dl_sched   = now_ext + WW'(cfg_i.window);
  assign cnt_inc    = count_q + CNT_W'(1);
  assign in_win_pre = (now_q >= cs_q) && (now_ext <= dl_q);
  assign full       = (count_q == CNT_W'(MAX_SENSORS));
  assign reach      = CMP_W'(cnt_inc) >= CMP_W'(cfg_i.expected);

  always_comb begin
    status_n   = cyct_pkg::ST_OUTSIDE;
    complete_n = 1'b0;
    sent_n     = 1'b0;
    sched      = 1'b0;
    tbl_wr     = 1'b0;
    count_d    = count_q;
    synced_d   = synced_q;
    last_d     = last_q;
    cs_d       = cs_q;
    dl_d       = dl_q;
    wake_d     = wake_q;
    unique case (func_q)
      cyct_pkg::FUNC_START: begin
        synced_d = 1'b1;
        sched    = 1'b1;
        status_n = cyct_pkg::ST_CYCLE;
      end
      cyct_pkg::FUNC_REPORT: begin
        priority if (!in_win_pre) begin
          status_n = cyct_pkg::ST_OUTSIDE;
        end else if (dup_q) begin
          status_n = cyct_pkg::ST_DUPLICATE;
        end else if (full) begin
          status_n = cyct_pkg::ST_FULL;
        end else begin
          tbl_wr   = cmd_i.commit;
          count_d  = cnt_inc;
          status_n = cyct_pkg::ST_ACCEPTED;
          if (reach) begin
            sched      = 1'b1;
            status_n   = cyct_pkg::ST_CYCLE;
            complete_n = 1'b1;
            // broadcast silently skipped until time is synchronized
            if (synced_q) begin
              last_d = now_q;
              sent_n = 1'b1;
            end
          end
        end
      end
      cyct_pkg::FUNC_BCAST: begin
        if (!synced_q) begin
          status_n = cyct_pkg::ST_REFUSED;
        end else begin
          last_d   = now_q;
          sent_n   = 1'b1;
          status_n = cyct_pkg::ST_BCAST;
        end
      end
      cyct_pkg::FUNC_QUERY: begin
        status_n = cyct_pkg::ST_OUTSIDE;
      end
      default: status_n = cyct_pkg::ST_OUTSIDE;
    endcase
    if (sched) begin
      wake_d  = wake_sched;
      cs_d    = now_q;
      dl_d    = dl_sched;
      count_d = '0;
    end
  end

  // status flags judged on the state after this request
  assign win_n = (now_q >= cs_d) && (now_ext <= dl_d);
  assign due_n = (now_q >= last_d) && ((now_q - last_d) >= NW'(cfg_i.bcast_iv));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cs_q     <= '0;
      dl_q     <= '0;
      wake_q   <= '0;
      last_q   <= '0;
      synced_q <= 1'b0;
    end else if (cmd_i.commit) begin
      count_q  <= count_d;
      cs_q     <= cs_d;
      dl_q     <= dl_d;
      wake_q   <= wake_d;
      last_q   <= last_d;
      synced_q <= synced_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q    <= status_n;
      rcount_q    <= cyct_pkg::RCNT_W'(count_d);
      complete_q  <= complete_n;
      win_q       <= win_n;
      sent_q      <= sent_n;
      next_wake_q <= wake_d;
      sleep_q     <= iv_eff;
      due_q       <= due_n;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.reported_count = rcount_q;
  assign rsp_o.cycle_complete = complete_q;
  assign rsp_o.window_active  = win_q;
  assign rsp_o.broadcast_sent = sent_q;
  assign rsp_o.next_wake      = next_wake_q;
  assign rsp_o.sleep_duration = sleep_q;
  assign rsp_o.broadcast_due  = due_q;

  `ASSERT_CLK(a_commit_has_room, clk_i, rst_ni, cmd_i.commit |-> !sts_o.out_blocked)
  `ASSERT_CLK(a_commit_shows_result, clk_i, rst_ni, cmd_i.commit |=> out_valid_q)
  `ASSERT_CLK_ALWAYS(a_count_bounded, clk_i, count_q <= CNT_W'(MAX_SENSORS))

endmodule

@@ design/collection_cycle_report_tracker.sv @@
// Top level: configuration registers, sequencer and datapath of the report tracker.
// Flow: an accepted request is captured, then the 32-step remainder divider and the table
// scan over the recorded entries run alongside each other; the result is registered at commit.
// A new request is taken only once the previous one has been committed; a waiting result
// does not block the next request from being accepted, only its commit.
// Reset: cycle state, counters and handshakes clear at once; table contents are kept.
module collection_cycle_report_tracker #(
  parameter int MAX_SENSORS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cyct_req_if.sink     req_i,
  cyct_rsp_if.source   rsp_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cyct_pkg::cfg_t cfg_q;
  cyct_pkg::cmd_t cmd;
  cyct_pkg::sts_t sts;
  cyct_pkg::reg_e reg_sel;
  logic           cfg_wr;
  logic           in_ready;

  assign pready  = 1'b1;
  assign reg_sel = cyct_pkg::reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval <= cyct_pkg::INTERVAL_RST;
      cfg_q.window   <= cyct_pkg::WINDOW_RST;
      cfg_q.expected <= cyct_pkg::EXPECTED_RST;
      cfg_q.bcast_iv <= cyct_pkg::BCAST_IV_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        cyct_pkg::REG_INTERVAL: cfg_q.interval <= pwdata[cyct_pkg::IV_W-1:0];
        cyct_pkg::REG_WINDOW:   cfg_q.window   <= pwdata[cyct_pkg::IV_W-1:0];
        cyct_pkg::REG_EXPECTED: cfg_q.expected <= pwdata[cyct_pkg::EXP_W-1:0];
        cyct_pkg::REG_BCAST_IV: cfg_q.bcast_iv <= pwdata[cyct_pkg::IV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      cyct_pkg::REG_INTERVAL: prdata = 32'(cfg_q.interval);
      cyct_pkg::REG_WINDOW:   prdata = 32'(cfg_q.window);
      cyct_pkg::REG_EXPECTED: prdata = 32'(cfg_q.expected);
      cyct_pkg::REG_BCAST_IV: prdata = 32'(cfg_q.bcast_iv);
      default:                prdata = '0;
    endcase
  end

  assign req_i.ready = in_ready;

  cyct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cyct_dp #(
    .MAX_SENSORS (MAX_SENSORS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .func_i       (req_i.func),
    .now_sec_i    (req_i.now_sec),
    .node_mac_i   (req_i.node_mac),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_o        (rsp_o)
  );

endmodule
